// ===== design/svl_pkg.sv =====
// ----------------------------------------------------------------------------
// svl_pkg
// Shared types and codes of the sorted value list: action and status codes,
// sequencer states and the compare unit's result bundle.
// ----------------------------------------------------------------------------
package svl_pkg;

  // action codes of an input word
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_DUMP   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // status codes of a result word
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_INS_WALK = 6'b000010,
    S_INS_PUT  = 6'b000100,
    S_DEL_WALK = 6'b001000,
    S_DMP_WALK = 6'b010000,
    S_RESP     = 6'b100000
  } state_t;

  // compare unit result
  typedef struct packed {
    logic le;
    logic eq;
  } cmp_t;

endpackage

// ===== design/svl_ram.sv =====
// ----------------------------------------------------------------------------
// svl_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module svl_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic signed [31:0]  wdata,
  input  logic [AW-1:0]       raddr,
  output logic signed [31:0]  rdata
);

  logic signed [31:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/svl_cmp.sv =====
// ----------------------------------------------------------------------------
// svl_cmp
// Shared compare unit: signed less-or-equal and equality of the held
// operand against the entry just read.
// ----------------------------------------------------------------------------
module svl_cmp
  import svl_pkg::*;
(
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output cmp_t               res
);

  // signed compare of operand against entry
  always_comb begin
    res.le = (a <= b);
    res.eq = (a == b);
  end

endmodule

// ===== design/sorted_value_list.sv =====
// ----------------------------------------------------------------------------
// sorted_value_list
// Ordered signed 32-bit store with insert, delete-all-equal and in-order dump,
// walked one entry per cycle via a shared compare unit; a dump waits on out_ready.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word: action and value.
//   Output channel (out_valid/out_ready) gives result words; the final word
//   of each input word has last set. Action code 3 is taken and ignored.
//   Insert: the walk runs from the top entry down, shifting each
//   greater-or-equal entry up; the value lands above the first smaller
//   entry, or in slot zero if there is none.
//   Delete: a single compacting pass through the list, one entry read
//   and at most one written per cycle.
//   Dump: entries go to the output register in order, one per cycle while
//   the receiver takes them; the single read port sets that pace.
//   Empty or full cases skip the walk and answer from the response state.
//   in_ready returns in the cycle the final result word first shows on the
//   output; that result may still sit in the output register while the
//   next word is taken.
//   A stalled receiver holds the output register; a dump then waits and
//   rereads the same entry until the word is taken.
//   Reset empties the list and drops any pending result; no clearing pass
//   is needed since the data of entries above occupancy is never used.
// ----------------------------------------------------------------------------
module sorted_value_list
  import svl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic [1:0]         status,
  output logic [4:0]         removed_count,
  output logic               last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t             state;
  logic [CW-1:0]      occ;
  logic [AW-1:0]      cur;
  logic [CW-1:0]      wr;
  logic signed [31:0] val;
  status_t            res_status;
  logic [4:0]         res_count;

  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic [AW-1:0]      raddr;
  logic signed [31:0] rdata;
  cmp_t               cmp;

  logic [CW-1:0]      occ_m1;
  logic [AW-1:0]      cur_top;
  logic [CW-1:0]      wr_fin;
  logic [CW-1:0]      n_removed;
  logic [CW+4:0]      n_ext;
  logic               out_free;
  logic               out_load;

  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign out_load  = out_free && ((state == S_DMP_WALK) || (state == S_RESP));
  assign occ_m1    = occ - CW'(1);
  assign cur_top   = occ_m1[AW-1:0];
  assign wr_fin    = wr + (cmp.eq ? CW'(0) : CW'(1));
  assign n_removed = occ - wr_fin;
  assign n_ext     = {5'd0, n_removed};

  // entry store and shared compare unit
  svl_ram #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  svl_cmp u_cmp (
    .a  (val),
    .b  (rdata),
    .res(cmp)
  );

  // memory port steering per state
  always_comb begin
    raddr = cur;
    we    = 1'b0;
    waddr = cur + AW'(1);
    wdata = val;
    case (state)
      S_IDLE: begin
        raddr = (action == ACT_INSERT) ? cur_top : '0;
        if (in_valid && action == ACT_INSERT && occ == '0) begin
          we    = 1'b1;
          waddr = '0;
          wdata = value;
        end
      end
      S_INS_WALK: begin
        raddr = cur - AW'(1);
        we    = 1'b1;
        waddr = cur + AW'(1);
        wdata = cmp.le ? rdata : val;
      end
      S_INS_PUT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = val;
      end
      S_DEL_WALK: begin
        raddr = cur + AW'(1);
        we    = !cmp.eq;
        waddr = wr[AW-1:0];
        wdata = rdata;
      end
      S_DMP_WALK: begin
        raddr = out_free ? cur + AW'(1) : cur;
      end
      default: begin
        raddr = cur;
      end
    endcase
  end

  // sequencer, occupancy and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            val       <= value;
            wr        <= '0;
            cur       <= (action == ACT_INSERT) ? cur_top : '0;
            res_count <= '0;
            case (action)
              ACT_INSERT: begin
                if (occ == CAP_C) begin
                  res_status <= ST_FULL;
                  state      <= S_RESP;
                end else if (occ == '0) begin
                  res_status <= ST_OK;
                  occ        <= occ + CW'(1);
                  state      <= S_RESP;
                end else begin
                  state <= S_INS_WALK;
                end
              end
              ACT_DELETE: begin
                if (occ == '0) begin
                  res_status <= ST_NOT_FOUND;
                  state      <= S_RESP;
                end else begin
                  state <= S_DEL_WALK;
                end
              end
              ACT_DUMP: begin
                if (occ == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_RESP;
                end else begin
                  state <= S_DMP_WALK;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_INS_WALK: begin
          // shift greater-or-equal entries up, drop value in above the first smaller
          if (cmp.le) begin
            if (cur == '0) begin
              state <= S_INS_PUT;
            end else begin
              cur <= cur - AW'(1);
            end
          end else begin
            occ        <= occ + CW'(1);
            res_status <= ST_OK;
            state      <= S_RESP;
          end
        end
        S_INS_PUT: begin
          occ        <= occ + CW'(1);
          res_status <= ST_OK;
          state      <= S_RESP;
        end
        S_DEL_WALK: begin
          // compact the surviving entries toward slot zero
          wr <= wr_fin;
          if (cur == cur_top) begin
            occ        <= wr_fin;
            res_count  <= n_ext[4:0];
            res_status <= (n_removed == '0) ? ST_NOT_FOUND : ST_OK;
            state      <= S_RESP;
          end else begin
            cur <= cur + AW'(1);
          end
        end
        S_DMP_WALK: begin
          // one entry per word as the receiver takes them
          if (out_free) begin
            out_value     <= rdata;
            status        <= ST_OK;
            removed_count <= '0;
            last          <= (cur == cur_top);
            if (cur == cur_top) begin
              state <= S_IDLE;
            end else begin
              cur <= cur + AW'(1);
            end
          end
        end
        S_RESP: begin
          // single result word of insert, delete or empty dump
          if (out_free) begin
            out_value     <= '0;
            status        <= res_status;
            removed_count <= res_count;
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/svl_chk.sv =====
// ----------------------------------------------------------------------------
// svl_chk
// Port-level checker of the sorted value list, bound to the top level.
// ----------------------------------------------------------------------------
module svl_chk
  import svl_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         action,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_value,
  input logic [1:0]         status,
  input logic [4:0]         removed_count,
  input logic               last
);

  // no result word straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid right after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value)
      && $stable(status) && $stable(removed_count) && $stable(last)))
    else $error("stalled result word changed");

  // a real action leaves the block busy in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action != ACT_NONE) |=> !in_ready)
    else $error("input taken again right after a real action");

  // error statuses only come as the single final word
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (last && out_value == '0))
    else $error("error status on a non-final or nonzero word");

  // a removal count only comes with an ok status
  a_count_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && removed_count != '0) |-> (status == ST_OK && last))
    else $error("removal count with bad status");

endmodule

bind sorted_value_list svl_chk u_svl_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .action       (action),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_value    (out_value),
  .status       (status),
  .removed_count(removed_count),
  .last         (last)
);
